// File: sv/rusi_pkg.sv
// Shared types and constants for the ray and unit sphere intersection pipeline.
package rusi_pkg;

   localparam int SQRT_STAGES = 32;

   localparam logic signed [48:0] ONE_Q32      = 49'sd4294967296;
   localparam logic [31:0]        THRESH_RESET = 32'd42950;
   localparam logic [22:0]        DIST_MAX     = 23'h7FFFFF;
   localparam logic [23:0]        PT_MAX       = 24'h7FFFFF;
   localparam logic [23:0]        PT_MIN       = 24'h800000;

   typedef logic [2:0][23:0] vec_type;

   // b = p.d and c = p.p - 1, both Q16.32
   typedef struct packed {
      logic signed [48:0] b;
      logic signed [48:0] c;
      vec_type            p;
      vec_type            d;
   } dot_type;

   // side data carried through the square root pipeline
   typedef struct packed {
      logic signed [48:0] b;
      logic               dneg;
      logic               tangent;
      vec_type            p;
      vec_type            d;
   } sqrt_pay_type;

   typedef struct packed {
      logic [63:0]  dmag;
      sqrt_pay_type pay;
   } disc_type;

   typedef struct packed {
      logic        hit;
      vec_type     point;
      logic [22:0] distance;
   } rsp_type;

endpackage

// File: sv/rusi_dot.sv
// Dot products b = p.d and c = p.p - 1 in two pipeline stages.
module rusi_dot
   import rusi_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   output logic    in_ready,
   input  vec_type in_p,
   input  vec_type in_d,
   output logic    out_valid,
   input  logic    out_ready,
   output dot_type out_data
);

   logic               v1_ff, v2_ff;
   logic               en1, en2;
   logic signed [47:0] pd_in [3];
   logic signed [47:0] pp_in [3];
   logic signed [47:0] pd_ff [3];
   logic signed [47:0] pp_ff [3];
   vec_type            p1_ff, d1_ff;
   dot_type            dot_in, dot_ff;

   // advance a stage when it is empty or the next one moves
   assign en2      = !v2_ff || out_ready;
   assign en1      = !v1_ff || en2;
   assign in_ready = en1;

   // stage 1: six products
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         pd_in[i] = $signed(in_p[i]) * $signed(in_d[i]);
         pp_in[i] = $signed(in_p[i]) * $signed(in_p[i]);
      end
   end

   // stage 2: sums
   always_comb begin
      dot_in.b = 49'(pd_ff[0]) + 49'(pd_ff[1]) + 49'(pd_ff[2]);
      dot_in.c = 49'(pp_ff[0]) + 49'(pp_ff[1]) + 49'(pp_ff[2]) - ONE_Q32;
      dot_in.p = p1_ff;
      dot_in.d = d1_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         if (en1) v1_ff <= in_valid;
         if (en2) v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en1) begin
         pd_ff <= pd_in;
         pp_ff <= pp_in;
         p1_ff <= in_p;
         d1_ff <= in_d;
      end
      if (en2) dot_ff <= dot_in;
   end

   assign out_valid = v2_ff;
   assign out_data  = dot_ff;

endmodule

// File: sv/rusi_disc.sv
// Discriminant b*b - c and tangency test in three pipeline stages.
module rusi_disc
   import rusi_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic [31:0] thresh,
   input  logic        in_valid,
   output logic        in_ready,
   input  dot_type     in_data,
   output logic        out_valid,
   input  logic        out_ready,
   output disc_type    out_data
);

   logic        v3_ff, v4_ff, v5_ff;
   logic        en3, en4, en5;
   logic [47:0] ub;
   logic [31:0] hh_in, hh_ff;
   logic [47:0] hl_in, hl_ff;
   logic [63:0] ll_in, ll_ff;
   logic [63:0] sq_in, sq_ff;
   dot_type     d3_ff, d4_ff;
   logic [47:0] cmag;
   logic [64:0] diff;
   disc_type    disc_in, disc_ff;

   assign en5      = !v5_ff || out_ready;
   assign en4      = !v4_ff || en5;
   assign en3      = !v3_ff || en4;
   assign in_ready = en3;

   // stage 3: partial products of |b| squared
   always_comb begin
      ub    = in_data.b[48] ? 48'(-in_data.b) : in_data.b[47:0];
      hh_in = ub[47:32] * ub[47:32];
      hl_in = ub[47:32] * ub[31:0];
      ll_in = ub[31:0] * ub[31:0];
   end

   // stage 4: floor(b*b / 2^32)
   assign sq_in = {hh_ff, 32'd0} + {15'd0, hl_ff, 1'b0} + {32'd0, ll_ff[63:32]};

   // stage 5: signed magnitude of the discriminant and tangency
   always_comb begin
      cmag = d4_ff.c[48] ? 48'(-d4_ff.c) : d4_ff.c[47:0];
      diff = {1'b0, sq_ff} - {17'd0, cmag};
      disc_in.pay.b = d4_ff.b;
      disc_in.pay.p = d4_ff.p;
      disc_in.pay.d = d4_ff.d;
      if (d4_ff.c[48]) begin
         disc_in.dmag     = sq_ff + {16'd0, cmag};
         disc_in.pay.dneg = 1'b0;
      end else if (!diff[64]) begin
         disc_in.dmag     = diff[63:0];
         disc_in.pay.dneg = 1'b0;
      end else begin
         disc_in.dmag     = 64'(-diff);
         disc_in.pay.dneg = 1'b1;
      end
      disc_in.pay.tangent = disc_in.dmag < {32'd0, thresh};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else begin
         if (en3) v3_ff <= in_valid;
         if (en4) v4_ff <= v3_ff;
         if (en5) v5_ff <= v4_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en3) begin
         hh_ff <= hh_in;
         hl_ff <= hl_in;
         ll_ff <= ll_in;
         d3_ff <= in_data;
      end
      if (en4) begin
         sq_ff <= sq_in;
         d4_ff <= d3_ff;
      end
      if (en5) disc_ff <= disc_in;
   end

   assign out_valid = v5_ff;
   assign out_data  = disc_ff;

endmodule

// File: sv/rusi_sqrt.sv
// Pipelined integer square root, one result bit per stage.
module rusi_sqrt
   import rusi_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         in_valid,
   output logic         in_ready,
   input  logic [63:0]  in_rad,
   input  sqrt_pay_type in_pay,
   output logic         out_valid,
   input  logic         out_ready,
   output logic [31:0]  out_root,
   output sqrt_pay_type out_pay
);

   logic               v_ff     [SQRT_STAGES];
   logic [33:0]        rem_ff   [SQRT_STAGES];
   logic [31:0]        root_ff  [SQRT_STAGES];
   logic [63:0]        rad_ff   [SQRT_STAGES];
   sqrt_pay_type       pay_ff   [SQRT_STAGES];
   logic [33:0]        rem_in   [SQRT_STAGES];
   logic [31:0]        root_in  [SQRT_STAGES];
   logic [63:0]        rad_in   [SQRT_STAGES];
   logic               v_src    [SQRT_STAGES];
   logic [33:0]        rem_src  [SQRT_STAGES];
   logic [31:0]        root_src [SQRT_STAGES];
   logic [63:0]        rad_src  [SQRT_STAGES];
   sqrt_pay_type       pay_src  [SQRT_STAGES];
   logic [SQRT_STAGES:0] en;

   // ready chain from the output back to the input
   always_comb begin
      en[SQRT_STAGES] = out_ready;
      for (int k = SQRT_STAGES - 1; k >= 0; k--) begin
         en[k] = !v_ff[k] || en[k+1];
      end
   end
   assign in_ready = en[0];

   // select what feeds each stage: the input for the first, the previous stage otherwise
   always_comb begin
      v_src[0]    = in_valid;
      rem_src[0]  = '0;
      root_src[0] = '0;
      rad_src[0]  = in_rad;
      pay_src[0]  = in_pay;
      for (int k = 1; k < SQRT_STAGES; k++) begin
         v_src[k]    = v_ff[k-1];
         rem_src[k]  = rem_ff[k-1];
         root_src[k] = root_ff[k-1];
         rad_src[k]  = rad_ff[k-1];
         pay_src[k]  = pay_ff[k-1];
      end
   end

   // one restoring step per stage
   always_comb begin
      logic [35:0] shifted;
      logic [35:0] trial;
      logic        ge;
      for (int k = 0; k < SQRT_STAGES; k++) begin
         shifted    = {rem_src[k], rad_src[k][63:62]};
         trial      = {2'b00, root_src[k], 2'b01};
         ge         = shifted >= trial;
         rem_in[k]  = ge ? 34'(shifted - trial) : shifted[33:0];
         root_in[k] = {root_src[k][30:0], ge};
         rad_in[k]  = {rad_src[k][61:0], 2'b00};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < SQRT_STAGES; k++) v_ff[k] <= 1'b0;
      end else begin
         for (int k = 0; k < SQRT_STAGES; k++) begin
            if (en[k]) v_ff[k] <= v_src[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < SQRT_STAGES; k++) begin
         if (en[k]) begin
            rem_ff[k]  <= rem_in[k];
            root_ff[k] <= root_in[k];
            rad_ff[k]  <= rad_in[k];
            pay_ff[k]  <= pay_src[k];
         end
      end
   end

   assign out_valid = v_ff[SQRT_STAGES-1];
   assign out_root  = root_ff[SQRT_STAGES-1];
   assign out_pay   = pay_ff[SQRT_STAGES-1];

endmodule

// File: sv/rusi_hit.sv
// Root selection, distance saturation and hit point in four pipeline stages.
module rusi_hit
   import rusi_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         in_valid,
   output logic         in_ready,
   input  logic [31:0]  in_root,
   input  sqrt_pay_type in_pay,
   output logic         out_valid,
   input  logic         out_ready,
   output rsp_type      out_data
);

   logic               va_ff, vb_ff, vc_ff, vd_ff;
   logic               ena, enb, enc, end_en;
   // stage a
   logic signed [50:0] nb, s16;
   logic signed [50:0] t1_in, t2_in, t1_ff, t2_ff;
   logic               any_in, two_in, any_ff, two_ff;
   vec_type            pa_ff, da_ff;
   // stage b
   logic               have1, use2, have_in, have_b_ff;
   logic signed [50:0] best;
   logic [22:0]        dist_in, dist_b_ff;
   vec_type            pb_ff, db_ff;
   // stage c
   logic signed [47:0] prod_in [3];
   logic signed [47:0] prod_ff [3];
   logic               have_c_ff;
   logic [22:0]        dist_c_ff;
   vec_type            pc_ff;
   // stage d
   rsp_type            rsp_in, rsp_ff;

   assign end_en   = !vd_ff || out_ready;
   assign enc      = !vc_ff || end_en;
   assign enb      = !vb_ff || enc;
   assign ena      = !va_ff || enb;
   assign in_ready = ena;

   // stage a: candidate roots; a tangent ray keeps only -b
   always_comb begin
      two_in = !in_pay.tangent && !in_pay.dneg;
      any_in = in_pay.tangent || !in_pay.dneg;
      nb     = -51'(in_pay.b);
      s16    = two_in ? $signed({3'b000, in_root, 16'd0}) : 51'sd0;
      t1_in  = nb + s16;
      t2_in  = nb - s16;
   end

   // stage b: nearest non-negative root, truncated to Q.16 and saturated
   always_comb begin
      have1   = any_ff && !t1_ff[50];
      use2    = two_ff && !t2_ff[50] && (!have1 || t2_ff < t1_ff);
      have_in = have1 || use2;
      best    = use2 ? t2_ff : t1_ff;
      dist_in = (|best[50:39]) ? DIST_MAX : best[38:16];
   end

   // stage c: direction times distance
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         prod_in[i] = $signed(db_ff[i]) * $signed({1'b0, dist_b_ff});
      end
   end

   // stage d: hit point with floor shift and saturation
   always_comb begin
      logic signed [32:0] q;
      rsp_in.hit      = have_c_ff;
      rsp_in.distance = have_c_ff ? dist_c_ff : DIST_MAX;
      for (int i = 0; i < 3; i++) begin
         q = 33'($signed(pc_ff[i])) + 33'(prod_ff[i] >>> 16);
         if (!have_c_ff)
            rsp_in.point[i] = '0;
         else if (q > 33'($signed(PT_MAX)))
            rsp_in.point[i] = PT_MAX;
         else if (q < 33'($signed(PT_MIN)))
            rsp_in.point[i] = PT_MIN;
         else
            rsp_in.point[i] = q[23:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
         vb_ff <= 1'b0;
         vc_ff <= 1'b0;
         vd_ff <= 1'b0;
      end else begin
         if (ena)    va_ff <= in_valid;
         if (enb)    vb_ff <= va_ff;
         if (enc)    vc_ff <= vb_ff;
         if (end_en) vd_ff <= vc_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ena) begin
         t1_ff  <= t1_in;
         t2_ff  <= t2_in;
         any_ff <= any_in;
         two_ff <= two_in;
         pa_ff  <= in_pay.p;
         da_ff  <= in_pay.d;
      end
      if (enb) begin
         have_b_ff <= have_in;
         dist_b_ff <= dist_in;
         pb_ff     <= pa_ff;
         db_ff     <= da_ff;
      end
      if (enc) begin
         prod_ff   <= prod_in;
         have_c_ff <= have_b_ff;
         dist_c_ff <= dist_b_ff;
         pc_ff     <= pb_ff;
      end
      if (end_en) rsp_ff <= rsp_in;
   end

   assign out_valid = vd_ff;
   assign out_data  = rsp_ff;

endmodule

// File: sv/ray_unit_sphere_intersect.sv
// An accepted request passes through 2 dot, 3 discriminant, 32 square root and 4 root
// select and hit point stages on its way to the response.
// Throughput: one ray per cycle unless stalled; the 32-stage square root sets the depth.
// A full stage waits while the next cannot advance; stalls lose and repeat nothing.
// Reset (synchronous, active high) empties the pipeline and sets the threshold to 42950.
module ray_unit_sphere_intersect
   import rusi_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z (24 bits each)
   input  logic [143:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // point_x, point_y, point_z (24 bits each), distance (23 bits), one zero pad bit
   output logic [95:0]  rsp_tdata,
   // hit
   output logic [0:0]   rsp_tuser,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [31:0]  csr_data
);

   logic [31:0]  thresh_ff;
   vec_type      req_p, req_d;
   logic         dot_valid, dot_ready;
   dot_type      dot_data;
   logic         disc_valid, disc_ready;
   disc_type     disc_data;
   logic         sq_valid, sq_ready;
   logic [31:0]  sq_root;
   sqrt_pay_type sq_pay;
   rsp_type      rsp_data;

   // take a threshold transaction in any cycle
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) thresh_ff <= THRESH_RESET;
      else if (csr_valid) thresh_ff <= csr_data;
   end

   // unpack the request
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         req_p[i] = req_tdata[24*i +: 24];
         req_d[i] = req_tdata[72 + 24*i +: 24];
      end
   end

   rusi_dot u_dot (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_p      (req_p),
      .in_d      (req_d),
      .out_valid (dot_valid),
      .out_ready (dot_ready),
      .out_data  (dot_data)
   );

   rusi_disc u_disc (
      .clock     (clock),
      .reset     (reset),
      .thresh    (thresh_ff),
      .in_valid  (dot_valid),
      .in_ready  (dot_ready),
      .in_data   (dot_data),
      .out_valid (disc_valid),
      .out_ready (disc_ready),
      .out_data  (disc_data)
   );

   rusi_sqrt u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (disc_valid),
      .in_ready  (disc_ready),
      .in_rad    (disc_data.dmag),
      .in_pay    (disc_data.pay),
      .out_valid (sq_valid),
      .out_ready (sq_ready),
      .out_root  (sq_root),
      .out_pay   (sq_pay)
   );

   rusi_hit u_hit (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (sq_valid),
      .in_ready  (sq_ready),
      .in_root   (sq_root),
      .in_pay    (sq_pay),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (rsp_data)
   );

   // pack the response
   assign rsp_tdata = {1'b0, rsp_data.distance, rsp_data.point[2], rsp_data.point[1],
                       rsp_data.point[0]};
   assign rsp_tuser = rsp_data.hit;

   // a miss carries a zero point and the maximum distance
   a_miss_format: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] |-> rsp_tdata[71:0] == 72'd0 && rsp_tdata[94:72] == DIST_MAX)
      else $error("miss response not in miss format");

   // reset empties the pipeline
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("response valid right after reset");

   // no response is valid right after reset is released
   a_no_early: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !rsp_tvalid)
      else $error("response appeared before the pipeline could fill");

endmodule

// File: sim/ray_unit_sphere_intersect_tb.sv
// Self-checking testbench for the ray and unit sphere intersection pipeline.
`timescale 1ns / 1ps

module ray_unit_sphere_intersect_tb
   import rusi_pkg::*;
();

   localparam int LATENCY     = 41;
   localparam int CYCLE_LIMIT = 400000;

   typedef struct {
      logic        hit;
      logic [23:0] px, py, pz;
      logic [22:0] distance;
   } hit_rec_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [143:0] req_tdata = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [95:0]  rsp_tdata;
   logic [0:0]   rsp_tuser;
   logic         csr_valid = 1'b0;
   logic         csr_ready;
   logic [31:0]  csr_data = '0;

   hit_rec_type hit_queue[$];
   logic [31:0] model_thresh;
   int          fail_count = 0;
   int          cycle_count = 0;
   int          hold_cycles = 0;
   bit          no_gaps = 1'b0;

   ray_unit_sphere_intersect u_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data)
   );

   always #4 clock = ~clock;

   // Bound the run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("ray_unit_sphere_intersect test failed");
         $finish;
      end
   end

   function automatic logic [63:0] floor_sqrt(logic [63:0] v);
      logic [63:0] res, bit_v;
      res = '0;
      bit_v = 64'd1 << 62;
      while (bit_v > v) bit_v = bit_v >> 2;
      while (bit_v != 0) begin
         if (v >= res + bit_v) begin
            v = v - (res + bit_v);
            res = (res >> 1) + bit_v;
         end else begin
            res = res >> 1;
         end
         bit_v = bit_v >> 2;
      end
      return res;
   endfunction

   function automatic logic signed [23:0] clamp24(logic signed [63:0] v);
      if (v > 64'sd8388607) return 24'sh7FFFFF;
      if (v < -64'sd8388608) return 24'sh800000;
      return v[23:0];
   endfunction

   // Compute the nearest non-negative intersection of one ray
   function automatic hit_rec_type intersect_ray(logic [143:0] data);
      logic signed [63:0] p[3], d[3], b, c, t1, t2, best, t16, prod, q;
      logic [127:0] bsq;
      logic [63:0]  sq, dmag, ub, s;
      logic         dneg, have;
      int           nroots;
      hit_rec_type  r;
      for (int i = 0; i < 3; i++) begin
         p[i] = {{40{data[24*i+23]}}, data[24*i +: 24]};
         d[i] = {{40{data[24*(i+3)+23]}}, data[24*(i+3) +: 24]};
      end
      b = p[0]*d[0] + p[1]*d[1] + p[2]*d[2];
      c = p[0]*p[0] + p[1]*p[1] + p[2]*p[2] - 64'sd4294967296;
      ub = (b < 0) ? -b : b;
      bsq = ub * ub;
      sq = bsq[95:32];
      if (c < 0) begin
         dneg = 1'b0; dmag = sq + 64'(-c);
      end else if (sq >= 64'(c)) begin
         dneg = 1'b0; dmag = sq - 64'(c);
      end else begin
         dneg = 1'b1; dmag = 64'(c) - sq;
      end
      t1 = -b; t2 = -b;
      if (dmag < {32'd0, model_thresh}) nroots = 1;
      else if (dneg) nroots = 0;
      else begin
         s = floor_sqrt(dmag);
         t1 = -b + $signed(s << 16);
         t2 = -b - $signed(s << 16);
         nroots = 2;
      end
      have = 1'b0; best = '0;
      if (nroots >= 1 && t1 >= 0) begin best = t1; have = 1'b1; end
      if (nroots == 2 && t2 >= 0 && (!have || t2 < best)) begin best = t2; have = 1'b1; end
      if (!have) begin
         r.hit = 1'b0; r.px = '0; r.py = '0; r.pz = '0; r.distance = 23'h7FFFFF;
         return r;
      end
      t16 = best >>> 16;
      if (t16 > 64'sd8388607) t16 = 64'sd8388607;
      r.hit = 1'b1;
      for (int i = 0; i < 3; i++) begin
         prod = d[i] * t16;
         q = clamp24(p[i] + (prod >>> 16));
         if (i == 0) r.px = q[23:0];
         else if (i == 1) r.py = q[23:0];
         else r.pz = q[23:0];
      end
      r.distance = t16[22:0];
      return r;
   endfunction

   // Offer one ray, record its expected hit on acceptance; valid stays up for the next one
   task automatic send_ray(logic [23:0] ox, oy, oz, dx, dy, dz);
      int gap;
      gap = no_gaps ? 0 : $urandom_range(0, 5);
      repeat (gap) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {dz, dy, dx, oz, oy, ox};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      hit_queue.push_back(intersect_ray({dz, dy, dx, oz, oy, ox}));
      @(negedge clock);
   endtask

   // Stop offering and wait until every expected response has come
   task automatic drain();
      req_tvalid <= 1'b0;
      while (hit_queue.size() != 0) @(negedge clock);
      repeat (LATENCY + 4) @(negedge clock);
   endtask

   task automatic write_thresh(logic [31:0] v);
      drain();
      csr_valid <= 1'b1;
      csr_data  <= v;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      model_thresh = v;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Receiver: random stall per transaction or always ready without gaps, plus long hold-offs on request
   initial begin
      int wait_n;
      forever begin
         @(negedge clock);
         if (hold_cycles > 0) begin
            rsp_tready <= 1'b0;
            hold_cycles = hold_cycles - 1;
         end else if (no_gaps) begin
            rsp_tready <= 1'b1;
         end else begin
            wait_n = $urandom_range(0, 5);
            if (wait_n > 0) begin
               rsp_tready <= 1'b0;
               repeat (wait_n) @(negedge clock);
            end
            rsp_tready <= 1'b1;
            @(posedge clock);
            while (!rsp_tvalid) @(posedge clock);
         end
      end
   end

   // Compare each response transaction with the oldest expectation
   always @(posedge clock) begin
      hit_rec_type e;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (hit_queue.size() == 0) begin
            $error("unexpected response");
            fail_count++;
         end else begin
            e = hit_queue.pop_front();
            if (rsp_tuser[0] !== e.hit) begin
               $error("hit exp %0h got %0h", e.hit, rsp_tuser[0]); fail_count++;
            end
            if (rsp_tdata[23:0] !== e.px) begin
               $error("point_x exp %0h got %0h", e.px, rsp_tdata[23:0]); fail_count++;
            end
            if (rsp_tdata[47:24] !== e.py) begin
               $error("point_y exp %0h got %0h", e.py, rsp_tdata[47:24]); fail_count++;
            end
            if (rsp_tdata[71:48] !== e.pz) begin
               $error("point_z exp %0h got %0h", e.pz, rsp_tdata[71:48]); fail_count++;
            end
            if (rsp_tdata[94:72] !== e.distance) begin
               $error("distance exp %0h got %0h", e.distance, rsp_tdata[94:72]);
               fail_count++;
            end
         end
      end
   end

   function automatic logic [23:0] rand_unitish();
      int v;
      v = $urandom_range(0, 131072) - 65536;
      return v[23:0];
   endfunction

   task automatic test_directed();
      logic [23:0] zr, one, mone, mx, mn, m2, p2, ff;
      zr = 24'h000000; one = 24'h010000; mone = 24'hFF0000;
      mx = 24'h7FFFFF; mn = 24'h800000; m2 = 24'hFE0000; p2 = 24'h020000;
      ff = 24'hFFFFFF;
      send_ray(zr, zr, m2, zr, zr, one);                          // two roots, ahead
      send_ray(zr, zr, m2, zr, zr, mone);                         // miss, behind
      send_ray(zr, zr, zr, one, zr, zr);                          // origin inside
      send_ray(one, m2, zr, zr, one, zr);                         // tangent graze
      send_ray(p2, zr, zr, zr, one, zr);                          // clear miss
      send_ray(zr, zr, zr, zr, zr, zr);                           // zero direction
      send_ray(mx, mx, mx, mx, mx, mx);
      send_ray(mn, mn, mn, mn, mn, mn);
      send_ray(mx, mn, mx, mn, mx, mn);
      send_ray(mn, zr, zr, mx, zr, zr);                           // huge distance
      send_ray(mx, zr, zr, mn, zr, zr);
      send_ray(zr, zr, zr, mx, mx, mx);                           // saturated point
      send_ray(one, zr, zr, one, zr, zr);                         // on surface
      send_ray(ff, ff, ff, ff, ff, ff);
   endtask

   task automatic test_random(int n);
      logic [23:0] o[3], dv[3];
      for (int k = 0; k < n; k++) begin
         for (int i = 0; i < 3; i++) begin
            case ($urandom_range(0, 3))
               0: o[i] = 24'($urandom());
               default: o[i] = 24'($urandom_range(0, 393216) - 196608);
            endcase
            dv[i] = ($urandom_range(0, 7) == 0) ? 24'($urandom()) : rand_unitish();
         end
         send_ray(o[0], o[1], o[2], dv[0], dv[1], dv[2]);
      end
   endtask

   // Fill the pipeline against a stalled receiver
   task automatic test_backpressure();
      no_gaps = 1'b1;
      hold_cycles = 120;
      test_random(100);
      no_gaps = 1'b0;
      drain();
   endtask

   initial begin
      model_thresh = THRESH_RESET;
      repeat (7) @(negedge clock);
      reset <= 1'b0;
      test_directed();
      test_random(300);
      write_thresh(32'd0);
      test_directed();
      test_random(250);
      write_thresh(32'hFFFFFFFF);
      test_directed();
      test_random(250);
      write_thresh($urandom_range(1, 32'h00FFFFFF));
      test_random(250);
      test_backpressure();
      write_thresh(THRESH_RESET);
      test_random(350);
      drain();
      if (fail_count == 0) $display("ray_unit_sphere_intersect test passed");
      else $display("ray_unit_sphere_intersect test failed");
      $finish;
   end

endmodule
